@@ hdl/hgp_pkg.sv @@
// Shared types and constants of the hexagon grid point locator.
`default_nettype none
package hgp_pkg;

  // Field widths.
  localparam int unsigned CoordW = 16;
  localparam int unsigned CellW  = 8;
  localparam int unsigned CfgW   = 8;
  localparam int unsigned CfgIdxW = 2;

  // sin60 in Q10 and the row pitch in 1/1024 pixel per unit of side.
  localparam int unsigned Sine60Q10 = 887;
  localparam int unsigned RowStep   = 16 * Sine60Q10;

  // Quotient bits produced by the column and row dividers.
  localparam int unsigned DivBits = 12;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_HEX_SIDE   = 2'd0,
    REG_BOARD_ROWS = 2'd1,
    REG_BOARD_COLS = 2'd2
  } cfg_reg_e;

endpackage
`default_nettype wire

@@ hdl/hgp_point_if.sv @@
// Input channel carrying one point word.
`default_nettype none
interface hgp_point_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [hgp_pkg::CoordW-1:0]     point_x;
  logic signed [hgp_pkg::CoordW-1:0]     point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink   (input valid, input point_x, input point_y, output ready);
endinterface
`default_nettype wire

@@ hdl/hgp_cell_if.sv @@
// Output channel carrying one cell word.
`default_nettype none
interface hgp_cell_if;
  logic                          valid;
  logic                          ready;
  logic [hgp_pkg::CellW-1:0]     cell_row;
  logic [hgp_pkg::CellW-1:0]     cell_col;

  modport source (output valid, output cell_row, output cell_col, input ready);
  modport sink   (input valid, input cell_row, input cell_col, output ready);
endinterface
`default_nettype wire

@@ hdl/hex_grid_point_to_cell.sv @@
// Throughput: one word per cycle; twelve restoring divider stages, one per
// quotient bit, run the column and row divisions side by side.
// A stalled output freezes every stage together; nothing is dropped or repeated.
// Reset clears all valid bits and loads side 32, rows 8, columns 12.
`default_nettype none
module hex_grid_point_to_cell (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire [hgp_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire [hgp_pkg::CfgW-1:0]          cfg_wdata_i,
  hgp_point_if.sink                        point_i,
  hgp_cell_if.source                       cell_o
);

  localparam int unsigned NDiv = hgp_pkg::DivBits;

  // Configuration registers.
  logic [7:0] side_q, rows_q, cols_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= 8'd32;
      rows_q <= 8'd8;
      cols_q <= 8'd12;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hgp_pkg::REG_HEX_SIDE:   side_q <= cfg_wdata_i;
        hgp_pkg::REG_BOARD_ROWS: rows_q <= cfg_wdata_i;
        hgp_pkg::REG_BOARD_COLS: cols_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Derived divisors and thresholds, refreshed every cycle.
  logic [12:0] dcol_q;
  logic [11:0] half_q;
  logic [21:0] drow_q;
  always_ff @(posedge clk_i) begin
    dcol_q <= {side_q, 4'b0} + {2'b0, side_q, 3'b0};
    half_q <= {side_q, 4'b0};
    drow_q <= 22'({14'b0, side_q} * 22'(hgp_pkg::RowStep));
  end

  // Whole pipeline advances unless the output word is stalled.
  logic en;
  assign en            = !cell_o.valid || cell_o.ready;
  assign point_i.ready = en;

  // Entry: flag bad points and form the dividends.
  logic signed [16:0] u;
  logic               kill_in;
  assign u       = $signed({2'b00, point_i.point_x[14:0]}) - $signed({6'b0, side_q, 3'b0});
  assign kill_in = point_i.point_x[15] | point_i.point_y[15] | (side_q == 8'd0);

  logic        v_q    [NDiv+1];
  logic        kill_q [NDiv+1];
  logic        uneg_q [NDiv+1];
  logic [14:0] x_q    [NDiv+1];
  logic [14:0] y_q    [NDiv+1];
  logic [14:0] cr_q   [NDiv+1];
  logic [11:0] cq_q   [NDiv+1];
  logic [24:0] rr_q   [NDiv+1];
  logic [11:0] rq_q   [NDiv+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en) begin
      v_q[0] <= point_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      kill_q[0] <= kill_in;
      uneg_q[0] <= u[16];
      x_q[0]    <= point_i.point_x[14:0];
      y_q[0]    <= point_i.point_y[14:0];
      cr_q[0]   <= u[16] ? 15'd0 : u[14:0];
      cq_q[0]   <= '0;
      rr_q[0]   <= {point_i.point_y[14:0], 10'b0};
      rq_q[0]   <= '0;
    end
  end

  // Divider stages: one quotient bit of each division per stage.
  for (genvar k = 0; k < NDiv; k++) begin : g_div
    localparam int unsigned B = NDiv - 1 - k;
    logic [24:0] ctrial, cdiv;
    logic [33:0] rtrial, rdiv;
    logic        cbit, rbit;

    assign ctrial = {10'b0, cr_q[k]};
    assign cdiv   = {12'b0, dcol_q} << B;
    assign cbit   = ctrial >= cdiv;
    assign rtrial = {9'b0, rr_q[k]};
    assign rdiv   = {12'b0, drow_q} << B;
    assign rbit   = rtrial >= rdiv;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        kill_q[k+1] <= kill_q[k];
        uneg_q[k+1] <= uneg_q[k];
        x_q[k+1]    <= x_q[k];
        y_q[k+1]    <= y_q[k];
        cr_q[k+1]   <= cbit ? 15'(ctrial - cdiv) : cr_q[k];
        cq_q[k+1]   <= {cq_q[k][10:0], cbit};
        rr_q[k+1]   <= rbit ? 25'(rtrial - rdiv) : rr_q[k];
        rq_q[k+1]   <= {rq_q[k][10:0], rbit};
      end
    end
  end

  // Candidate selection by parity rules.
  logic [12:0] c1, c2, r1, r2, t13;
  logic        c2ok, r2ok, kill_all;
  logic [7:0]  s_row_d, s_col_d, ar_d, ac_d, br_d, bc_d;
  logic        need_d;

  always_comb begin
    t13      = {1'b0, rq_q[NDiv]};
    c1       = uneg_q[NDiv] ? 13'd1 : {1'b0, cq_q[NDiv]} + 13'd1;
    c2       = c1 + 13'd1;
    c2ok     = !uneg_q[NDiv] && ({3'b0, cr_q[NDiv]} > {6'b0, half_q})
               && (c2 <= {5'b0, cols_q});
    r1       = t13[0] ? t13 : t13 + 13'd1;
    r2       = t13[0] ? t13 + 13'd1 : t13;
    r2ok     = (r2 != 13'd0) && (r2 < {5'b0, rows_q});
    kill_all = kill_q[NDiv] || (c1 > {5'b0, cols_q}) || (r1 > {5'b0, rows_q});
    s_row_d  = '0;
    s_col_d  = '0;
    need_d   = 1'b0;
    ar_d     = r1[7:0];
    br_d     = r2[7:0];
    ac_d     = c1[0] ? c1[7:0] : c2[7:0];
    bc_d     = c1[0] ? c2[7:0] : c1[7:0];
    priority if (kill_all) begin
      need_d = 1'b0;
    end else if (!r2ok && !c2ok) begin
      if (c1[0]) begin
        s_row_d = r1[7:0];
        s_col_d = c1[7:0];
      end
    end else if (!r2ok) begin
      s_row_d = r1[7:0];
      s_col_d = c1[0] ? c1[7:0] : c2[7:0];
    end else if (!c2ok) begin
      s_row_d = c1[0] ? r1[7:0] : r2[7:0];
      s_col_d = c1[7:0];
    end else begin
      need_d = 1'b1;
    end
  end

  logic       sel_v_q, sel_need_q;
  logic [7:0] sel_row_q, sel_col_q, ar_q, ac_q, br_q, bc_q;
  logic [14:0] sel_x_q, sel_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_v_q <= 1'b0;
    end else if (en) begin
      sel_v_q <= v_q[NDiv];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sel_need_q <= need_d;
      sel_row_q  <= s_row_d;
      sel_col_q  <= s_col_d;
      ar_q       <= ar_d;
      ac_q       <= ac_d;
      br_q       <= br_d;
      bc_q       <= bc_d;
      sel_x_q    <= x_q[NDiv];
      sel_y_q    <= y_q[NDiv];
    end
  end

  // Center offsets times side.
  logic [12:0] ka, kb;
  assign ka = {1'b0, ac_q, 4'b0} + {2'b0, ac_q, 3'b0} - 13'd8;
  assign kb = {1'b0, bc_q, 4'b0} + {2'b0, bc_q, 3'b0} - 13'd8;

  logic        d1_v_q, d1_need_q;
  logic [7:0]  d1_row_q, d1_col_q, d1_ar_q, d1_ac_q, d1_br_q, d1_bc_q;
  logic [14:0] d1_x_q, d1_y_q;
  logic [20:0] pa_q, pb_q;
  logic [15:0] ra_q, rb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_v_q <= 1'b0;
    end else if (en) begin
      d1_v_q <= sel_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_need_q <= sel_need_q;
      d1_row_q  <= sel_row_q;
      d1_col_q  <= sel_col_q;
      d1_ar_q   <= ar_q;
      d1_ac_q   <= ac_q;
      d1_br_q   <= br_q;
      d1_bc_q   <= bc_q;
      d1_x_q    <= sel_x_q;
      d1_y_q    <= sel_y_q;
      pa_q      <= {8'b0, ka} * {13'b0, side_q};
      pb_q      <= {8'b0, kb} * {13'b0, side_q};
      ra_q      <= {8'b0, ar_q} * {8'b0, side_q};
      rb_q      <= {8'b0, br_q} * {8'b0, side_q};
    end
  end

  // Signed offsets from both centers, then magnitudes.
  logic signed [22:0] exa, exb;
  logic signed [31:0] eya, eyb;
  logic [29:0]        cya, cyb;
  assign cya = 30'({14'b0, d1_ar_q == 8'd0 ? 16'd0 : ra_q} * 30'(hgp_pkg::RowStep));
  assign cyb = 30'({14'b0, rb_q} * 30'(hgp_pkg::RowStep));
  assign exa = $signed({8'b0, d1_x_q}) - $signed({2'b0, pa_q});
  assign exb = $signed({8'b0, d1_x_q}) - $signed({2'b0, pb_q});
  assign eya = $signed({7'b0, d1_y_q, 10'b0}) - $signed({2'b0, cya});
  assign eyb = $signed({7'b0, d1_y_q, 10'b0}) - $signed({2'b0, cyb});

  logic        d2_v_q, d2_need_q;
  logic [7:0]  d2_row_q, d2_col_q, d2_ar_q, d2_ac_q, d2_br_q, d2_bc_q;
  logic [21:0] axa_q, axb_q;
  logic [30:0] aya_q, ayb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d2_v_q <= 1'b0;
    end else if (en) begin
      d2_v_q <= d1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d2_need_q <= d1_need_q;
      d2_row_q  <= d1_row_q;
      d2_col_q  <= d1_col_q;
      d2_ar_q   <= d1_ar_q;
      d2_ac_q   <= d1_ac_q;
      d2_br_q   <= d1_br_q;
      d2_bc_q   <= d1_bc_q;
      axa_q     <= exa[22] ? 22'(-exa) : exa[21:0];
      axb_q     <= exb[22] ? 22'(-exb) : exb[21:0];
      aya_q     <= eya[31] ? 31'(-eya) : eya[30:0];
      ayb_q     <= eyb[31] ? 31'(-eyb) : eyb[30:0];
    end
  end

  // Squares of each axis; x is scaled by 2^20 to match the y units.
  logic        d3_v_q, d3_need_q;
  logic [7:0]  d3_row_q, d3_col_q, d3_ar_q, d3_ac_q, d3_br_q, d3_bc_q;
  logic [43:0] sxa_q, sxb_q;
  logic [61:0] sya_q, syb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d3_v_q <= 1'b0;
    end else if (en) begin
      d3_v_q <= d2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d3_need_q <= d2_need_q;
      d3_row_q  <= d2_row_q;
      d3_col_q  <= d2_col_q;
      d3_ar_q   <= d2_ar_q;
      d3_ac_q   <= d2_ac_q;
      d3_br_q   <= d2_br_q;
      d3_bc_q   <= d2_bc_q;
      sxa_q     <= {22'b0, axa_q} * {22'b0, axa_q};
      sxb_q     <= {22'b0, axb_q} * {22'b0, axb_q};
      sya_q     <= {31'b0, aya_q} * {31'b0, aya_q};
      syb_q     <= {31'b0, ayb_q} * {31'b0, ayb_q};
    end
  end

  // Sum, compare and pick the nearer center; ties go to the second.
  logic [63:0] da, db;
  logic        a_wins;
  logic [7:0]  row_d, col_d;
  assign da     = {sxa_q, 20'b0} + {2'b0, sya_q};
  assign db     = {sxb_q, 20'b0} + {2'b0, syb_q};
  assign a_wins = da < db;
  assign row_d  = !d3_need_q ? d3_row_q : (a_wins ? d3_ar_q : d3_br_q);
  assign col_d  = !d3_need_q ? d3_col_q : (a_wins ? d3_ac_q : d3_bc_q);

  logic       out_v_q;
  logic [7:0] out_row_q, out_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= d3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_row_q <= row_d;
      out_col_q <= col_d;
    end
  end

  assign cell_o.valid    = out_v_q;
  assign cell_o.cell_row = out_row_q;
  assign cell_o.cell_col = out_col_q;

endmodule
`default_nettype wire

@@ bench/hex_grid_point_to_cell_tb.sv @@
// Self-checking bench for the hexagon grid point locator: random and directed points.
`default_nettype none
module hex_grid_point_to_cell_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [hgp_pkg::CoordW-1:0] x;
    logic signed [hgp_pkg::CoordW-1:0] y;
  } point_t;

  typedef struct packed {
    logic [hgp_pkg::CellW-1:0] row;
    logic [hgp_pkg::CellW-1:0] col;
  } cell_t;

  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned DrainCycles = 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  hgp_pkg::cfg_reg_e cfg_idx_i = hgp_pkg::REG_HEX_SIDE;
  logic [hgp_pkg::CfgW-1:0] cfg_wdata_i = '0;

  hgp_point_if point_ch ();
  hgp_cell_if cell_ch ();

  hex_grid_point_to_cell DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .point_i    (point_ch.sink),
    .cell_o     (cell_ch.source)
  );

  // Bench copy of the registers.
  int unsigned side_q = 32;
  int unsigned rows_q = 8;
  int unsigned cols_q = 12;

  point_t pending_points[$];
  cell_t expected_cells[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit sender_hold = 1'b0;
  bit sink_hold = 1'b0;
  int unsigned hold_len = 0;
  bit timed_out = 1'b0;
  bit point_taken = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Squared distance from a point (scaled by 1024) to a cell center.
  function automatic longint unsigned center_dist2(longint px, longint py, longint row,
                                                   longint col, longint s);
    longint cx, cy, dx, dy;
    cx = (24 * col - 8) * s * 1024;
    cy = 16 * longint'(hgp_pkg::Sine60Q10) * row * s;
    dx = px - cx;
    dy = py - cy;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return longint'(dx * dx + dy * dy);
  endfunction

  // Locate the cell that holds a point under the current register values.
  function automatic cell_t locate_cell(point_t p);
    longint x, y, s, rows, cols, c1, c2, r1, r2, t, u, q, rem, ar, ac, br, bc;
    cell_t res;
    x = longint'(p.x);
    y = longint'(p.y);
    s = side_q;
    rows = rows_q;
    cols = cols_q;
    res = '0;
    if (x < 0 || y < 0 || s == 0) return res;
    u = x - 8 * s;
    if (u < 0) begin
      c1 = 1;
      c2 = 0;
    end else begin
      q = u / (24 * s);
      rem = u - q * 24 * s;
      c1 = q + 1;
      c2 = (rem > 16 * s && c1 + 1 <= cols) ? c1 + 1 : 0;
    end
    if (c1 > cols) return res;
    t = (y * 1024) / (16 * s * longint'(hgp_pkg::Sine60Q10));
    r1 = t;
    r2 = t;
    if (t[0] == 1'b0) r1 = t + 1;
    else r2 = t + 1;
    if (r1 > rows) return res;
    if (r2 > rows - 1) r2 = 0;
    if (r2 == 0 && c2 == 0) begin
      if (c1[0]) begin
        res.row = r1[7:0];
        res.col = c1[7:0];
      end
    end else if (r2 == 0) begin
      res.row = r1[7:0];
      res.col = c1[0] ? c1[7:0] : c2[7:0];
    end else if (c2 == 0) begin
      res.row = c1[0] ? r1[7:0] : r2[7:0];
      res.col = c1[7:0];
    end else begin
      ar = r1;
      br = r2;
      ac = c1[0] ? c1 : c2;
      bc = c1[0] ? c2 : c1;
      if (center_dist2(x * 1024, y * 1024, ar, ac, s) <
          center_dist2(x * 1024, y * 1024, br, bc, s)) begin
        res.row = ar[7:0];
        res.col = ac[7:0];
      end else begin
        res.row = br[7:0];
        res.col = bc[7:0];
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch: %s", what);
    mismatches++;
  endtask

  // Append one point word to the pending queue.
  function automatic void add_point(point_t p);
    pending_points.insert(pending_points.size(), p);
  endfunction

  // Drive point words from the pending queue in bursts with gaps.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  always @(posedge clk_i) begin
    point_taken = point_ch.valid && point_ch.ready;
    if (point_taken) begin
      expected_cells.insert(expected_cells.size(), locate_cell(pending_points.pop_front()));
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      point_ch.valid <= 1'b0;
    end else if (point_ch.valid && !point_taken) begin
      point_ch.valid <= 1'b1;
    end else if (sender_hold || pending_points.size() == 0) begin
      point_ch.valid <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
      point_ch.valid <= 1'b0;
    end else begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      end
      burst_left--;
      point_ch.valid <= 1'b1;
      point_ch.point_x <= pending_points[0].x;
      point_ch.point_y <= pending_points[0].y;
    end
  end

  // Stall the receiver on its own pattern, plus one long hold-off.
  int unsigned stall_phase = 0;
  always @(negedge clk_i) begin
    stall_phase++;
    if (sink_hold && hold_len > 0) begin
      hold_len--;
      cell_ch.ready <= 1'b0;
    end else if (stall_phase % 512 < 128) begin
      cell_ch.ready <= 1'b1;
    end else begin
      cell_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Check each accepted cell word against the oldest expectation.
  always @(posedge clk_i) begin
    cell_t exp_cell;
    if (rst_ni && cell_ch.valid && cell_ch.ready) begin
      if (expected_cells.size() == 0) begin
        report_mismatch("cell word with none expected");
      end else begin
        exp_cell = expected_cells.pop_front();
        if (cell_ch.cell_row !== exp_cell.row)
          report_mismatch($sformatf("row %0d, expected %0d", cell_ch.cell_row, exp_cell.row));
        if (cell_ch.cell_col !== exp_cell.col)
          report_mismatch($sformatf("col %0d, expected %0d", cell_ch.cell_col, exp_cell.col));
      end
    end
  end

  // Watchdog on cycles with no accepted word.
  always @(posedge clk_i) begin
    if ((point_ch.valid && point_ch.ready) || (cell_ch.valid && cell_ch.ready) ||
        (pending_points.size() == 0 && expected_cells.size() == 0))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("[hex_grid_point_to_cell] ERROR");
      $finish;
    end
  end

  task automatic write_reg(hgp_pkg::cfg_reg_e idx, int unsigned value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value[7:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      hgp_pkg::REG_HEX_SIDE: side_q = value;
      hgp_pkg::REG_BOARD_ROWS: rows_q = value;
      default: cols_q = value;
    endcase
  endtask

  task automatic drain_all();
    while (pending_points.size() > 0 || expected_cells.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic point_t rand_point();
    point_t p;
    int unsigned span;
    span = (24 * side_q * (cols_q + 1)) + 64;
    if ($urandom_range(0, 9) == 0) begin
      p.x = 16'($urandom);
      p.y = 16'($urandom);
    end else begin
      p.x = (span > 32767) ? 16'($urandom_range(0, 32767)) : 16'($urandom_range(0, span));
      span = (14 * side_q * (rows_q + 1)) + 64;
      p.y = (span > 32767) ? 16'($urandom_range(0, 32767)) : 16'($urandom_range(0, span));
    end
    return p;
  endfunction

  function automatic point_t mk_point(int x, int y);
    point_t p;
    p.x = x[15:0];
    p.y = y[15:0];
    return p;
  endfunction

  initial begin
    int unsigned s;
    point_ch.valid = 1'b0;
    point_ch.point_x = '0;
    point_ch.point_y = '0;
    cell_ch.ready = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed points at reset settings: extremes, edges, ties.
    s = side_q;
    add_point(mk_point(-1, 100));
    add_point(mk_point(100, -1));
    add_point(mk_point(-32768, -32768));
    add_point(mk_point(32767, 32767));
    add_point(mk_point(0, 0));
    add_point(mk_point(8 * s - 1, 10));
    add_point(mk_point(8 * s, 10));
    add_point(mk_point(24 * s, 200));
    add_point(mk_point(24 * s + 8 * s + 1, 200));
    add_point(mk_point(40 * s, 886 * s / 64));
    add_point(mk_point(32 * s + 1, 887 * s / 64));
    add_point(mk_point(400, 16 * s * 8));
    add_point(mk_point(24 * s * 12, 400));
    add_point(mk_point(24 * s * 11 + 8 * s + 1, 400));
    add_point(mk_point(33 * s, 2000));
    add_point(mk_point(16'h5555, 16'h2aaa));
    drain_all();

    // Phases over register settings, extremes included.
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: begin write_reg(hgp_pkg::REG_HEX_SIDE, 1); write_reg(hgp_pkg::REG_BOARD_ROWS, 255);
                 write_reg(hgp_pkg::REG_BOARD_COLS, 255); end
        1: begin write_reg(hgp_pkg::REG_HEX_SIDE, 255); write_reg(hgp_pkg::REG_BOARD_ROWS, 1);
                 write_reg(hgp_pkg::REG_BOARD_COLS, 1); end
        2: begin write_reg(hgp_pkg::REG_HEX_SIDE, 0); end
        3: begin write_reg(hgp_pkg::REG_HEX_SIDE, 7); write_reg(hgp_pkg::REG_BOARD_ROWS, 0);
                 write_reg(hgp_pkg::REG_BOARD_COLS, 20); end
        4: begin write_reg(hgp_pkg::REG_BOARD_ROWS, 30);
                 write_reg(hgp_pkg::REG_BOARD_COLS, 0); end
        default: begin
          write_reg(hgp_pkg::REG_HEX_SIDE, $urandom_range(1, 255));
          write_reg(hgp_pkg::REG_BOARD_ROWS, $urandom_range(1, 255));
          write_reg(hgp_pkg::REG_BOARD_COLS, $urandom_range(1, 255));
        end
      endcase
      for (int i = 0; i < ((ph < 5) ? 60 : 250); i++) add_point(rand_point());
      if (ph == 5) begin
        // Hold the receiver off so the pipeline fills and stalls its input.
        @(negedge clk_i);
        hold_len = 300;
        sink_hold = 1'b1;
        while (hold_len > 0) @(negedge clk_i);
        sink_hold = 1'b0;
      end
      if (ph == 6) begin
        // Pause the sender until every expected cell word has come.
        while (pending_points.size() > 100) @(posedge clk_i);
        sender_hold = 1'b1;
        while (expected_cells.size() > 0) @(posedge clk_i);
        sender_hold = 1'b0;
      end
      drain_all();
    end

    if (mismatches == 0 && expected_cells.size() == 0)
      $display("[hex_grid_point_to_cell] OK");
    else
      $display("[hex_grid_point_to_cell] ERROR");
    $finish;
  end
endmodule
`default_nettype wire

@@ sim.f @@
hdl/hgp_pkg.sv
hdl/hgp_point_if.sv
hdl/hgp_cell_if.sv
hdl/hex_grid_point_to_cell.sv
bench/hex_grid_point_to_cell_tb.sv
